// ===== rtl/cds_pkg.sv =====
package cds_pkg;

    // fixed-point format of all positions, velocities and times
    localparam int FB = 16;

    localparam int WORD_W = 32;
    localparam int CFG_W  = 31;
    localparam int ADDR_W = 2;
    localparam int DATA_W = 4 * WORD_W;

    // register indexes on the write port
    localparam logic [ADDR_W-1:0] REG_SMOOTH_TIME = 2'd0;
    localparam logic [ADDR_W-1:0] REG_TICK_TIME   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MAX_SPEED   = 2'd2;

    localparam logic [CFG_W-1:0] SMOOTH_TIME_RST = 31'd65536;
    localparam logic [CFG_W-1:0] TICK_TIME_RST   = 31'd1092;
    localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 31'h7fff_ffff;

    // rounded constants of the exp approximation and the smooth time floor
    localparam longint ONE_I     = longint'(1) << FB;
    localparam longint FLOOR_I   = (ONE_I + 5000) / 10000;
    localparam longint FLOOR_V   = (FLOOR_I == 0) ? 1 : FLOOR_I;
    localparam longint K048_I    = (48 * ONE_I + 50) / 100;
    localparam longint K0235_I   = (235 * ONE_I + 500) / 1000;

    localparam logic [CFG_W-1:0]  ST_FLOOR = CFG_W'(FLOOR_V);
    localparam logic [WORD_W-1:0] K048     = WORD_W'(K048_I);
    localparam logic [WORD_W-1:0] K0235    = WORD_W'(K0235_I);

    // widths of the unsigned exp path
    localparam int X_W    = 48;
    localparam int U_W    = 57;
    localparam int D_W    = 59;
    localparam int ACC_W  = 80;
    localparam int PROD_W = 64;
    localparam int DIVD_W = 2 * FB + 2;
    localparam int EX_W   = FB + 1;

    localparam logic [U_W-1:0]    UCAP     = U_W'(1) << 56;
    localparam logic [D_W-1:0]    ONE_D    = D_W'(ONE_I);
    localparam logic [DIVD_W-1:0] OM_DIVD  = DIVD_W'(1) << (2 * FB + 1);
    localparam logic [DIVD_W-1:0] EX_DIVD  = DIVD_W'(1) << (2 * FB);

    localparam logic signed [33:0] S32_MAX_W = 34'sh0_7fff_ffff;
    localparam logic signed [33:0] S32_MIN_W = 34'sh3_8000_0000;

    typedef enum logic [5:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_DIV_OM,
        OP_WAIT_OM,
        OP_MUL_XT,
        OP_TAKE_X,
        OP_MUL_XX,
        OP_TAKE_X2,
        OP_MUL_X3L,
        OP_MUL_X3H,
        OP_ACC,
        OP_TAKE_X3,
        OP_MUL_T2L,
        OP_MUL_T2H,
        OP_TAKE_T2,
        OP_MUL_T3L,
        OP_MUL_T3H,
        OP_TAKE_T3,
        OP_DIV_EX,
        OP_WAIT_EX,
        OP_MUL_LIM,
        OP_TAKE_LIM,
        OP_CHANGE,
        OP_LIMTGT,
        OP_S1,
        OP_MUL_T,
        OP_TEMP,
        OP_MUL_A2,
        OP_S2,
        OP_MUL_V,
        OP_VEL,
        OP_MUL_O,
        OP_OUT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic axis;
    } cds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } cds_sts_t;

    localparam int CONST_LEN = 22;
    localparam int AXIS_LEN  = 11;
    localparam int PC_W      = $clog2(CONST_LEN);
    localparam int APC_W     = $clog2(AXIS_LEN);

    // constant terms, run once after reset or a register write
    localparam op_t CONST_PROG [CONST_LEN] = '{
        OP_DIV_OM, OP_WAIT_OM, OP_MUL_XT, OP_TAKE_X, OP_MUL_XX, OP_TAKE_X2,
        OP_MUL_X3L, OP_MUL_X3H, OP_ACC, OP_TAKE_X3,
        OP_MUL_T2L, OP_MUL_T2H, OP_ACC, OP_TAKE_T2,
        OP_MUL_T3L, OP_MUL_T3H, OP_ACC, OP_TAKE_T3,
        OP_DIV_EX, OP_WAIT_EX, OP_MUL_LIM, OP_TAKE_LIM
    };

    // per-axis step
    localparam op_t AXIS_PROG [AXIS_LEN] = '{
        OP_CHANGE, OP_LIMTGT, OP_S1, OP_MUL_T, OP_TEMP, OP_MUL_A2,
        OP_S2, OP_MUL_V, OP_VEL, OP_MUL_O, OP_OUT
    };

    function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX_W) r = 32'sh7fff_ffff;
        else if (v < S32_MIN_W) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    // finish a sign-magnitude product: drop fraction bits, apply sign, saturate
    function automatic logic signed [31:0] qfin(input logic [PROD_W-1:0] p, input logic neg);
        logic [PROD_W-1:0] m;
        logic signed [31:0] r;
        m = p >> FB;
        if (!neg) r = (m > PROD_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(m[31:0]);
        else r = (m > PROD_W'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(32'(-m[31:0]));
        return r;
    endfunction

endpackage

// ===== rtl/cds_div.sv =====
module cds_div
    import cds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [D_W-1:0]    divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [D_W-1:0]    rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [D_W-1:0]    dvsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [D_W:0] rem_sh;
    logic [D_W:0] rem_sub;
    logic         ge;
    logic [D_W-1:0] rem_next;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvsr_reg};
        ge       = rem_sh >= {1'b0, dvsr_reg};
        rem_next = ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/cds_datapath.sv =====
module cds_datapath
    import cds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cds_cmd_t          cmd,
    output cds_sts_t          sts,
    input  logic [DATA_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    logic [CFG_W-1:0] smooth_time_reg;
    logic [CFG_W-1:0] tick_time_reg;
    logic [CFG_W-1:0] max_speed_reg;

    logic signed [31:0] cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg;
    logic signed [31:0] res_px_reg, res_py_reg, res_vx_reg, res_vy_reg;
    logic [DATA_W-1:0]  m_tdata_reg;
    logic               m_tvalid_reg;

    logic [CFG_W-1:0]  st_reg;
    logic [CFG_W-1:0]  om_reg;
    logic [X_W-1:0]    x_reg;
    logic [U_W-1:0]    x2_reg;
    logic [U_W-1:0]    x3_reg;
    logic [D_W-1:0]    d_reg;
    logic [EX_W-1:0]   ex_reg;
    logic [CFG_W-1:0]  lim_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              neg_reg;

    logic signed [31:0] change_reg, limtgt_reg, s_reg, s3_reg, temp_reg, vnew_reg;

    logic [CFG_W-1:0]   st_next;
    logic [31:0]        mul_a, mul_b;
    logic               mul_en;
    logic               neg_next;
    logic signed [31:0] cur_s, tgt_s, vel_s, qv;
    logic signed [31:0] diff_s, lim_s, change_next, out_raw, out_next, vel_next;
    logic               ovs;
    logic               out_free;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  div_dividend, div_q;
    logic [D_W-1:0]     div_divisor;

    assign st_next  = (smooth_time_reg < ST_FLOOR) ? ST_FLOOR : smooth_time_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign div_start    = (cmd.op == OP_DIV_OM) || (cmd.op == OP_DIV_EX);
    assign div_dividend = (cmd.op == OP_DIV_OM) ? OM_DIVD : EX_DIVD;
    assign div_divisor  = (cmd.op == OP_DIV_OM) ? D_W'(st_next) : d_reg;

    cds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cur_s = cmd.axis ? cur_y_reg : cur_x_reg;
    assign tgt_s = cmd.axis ? tgt_y_reg : tgt_x_reg;
    assign vel_s = cmd.axis ? vel_y_reg : vel_x_reg;
    assign qv    = qfin(prod_reg, neg_reg);
    assign lim_s = $signed({1'b0, lim_reg});

    // difference clamped to the distance limit
    always_comb
    begin
        diff_s = sat32(sx34(cur_s) - sx34(tgt_s));
        if (diff_s > lim_s) change_next = lim_s;
        else if (diff_s < -lim_s) change_next = -lim_s;
        else change_next = diff_s;
    end

    // final position, with snap to target on overshoot
    always_comb
    begin
        out_raw  = sat32(sx34(limtgt_reg) + sx34(qv));
        ovs      = (tgt_s > cur_s) == (out_raw > tgt_s);
        out_next = ovs ? tgt_s : out_raw;
        vel_next = ovs ? 32'sd0 : vnew_reg;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        mul_en   = 1'b1;
        neg_next = 1'b0;
        unique case (cmd.op)
            OP_MUL_XT:  begin mul_a = 32'(om_reg);         mul_b = 32'(tick_time_reg); end
            OP_MUL_XX:  begin mul_a = x_reg[31:0];         mul_b = x_reg[31:0]; end
            OP_MUL_X3L: begin mul_a = x2_reg[31:0];        mul_b = x_reg[31:0]; end
            OP_MUL_X3H: begin mul_a = 32'(x2_reg[47:32]);  mul_b = x_reg[31:0]; end
            OP_MUL_T2L: begin mul_a = x2_reg[31:0];        mul_b = K048; end
            OP_MUL_T2H: begin mul_a = 32'(x2_reg[47:32]);  mul_b = K048; end
            OP_MUL_T3L: begin mul_a = x3_reg[31:0];        mul_b = K0235; end
            OP_MUL_T3H: begin mul_a = 32'(x3_reg[47:32]);  mul_b = K0235; end
            OP_MUL_LIM: begin mul_a = 32'(st_reg);         mul_b = 32'(max_speed_reg); end
            OP_LIMTGT:
            begin
                mul_a    = 32'(om_reg);
                mul_b    = mag32(change_reg);
                neg_next = change_reg[31];
            end
            OP_MUL_T:
            begin
                mul_a    = mag32(s_reg);
                mul_b    = 32'(tick_time_reg);
                neg_next = s_reg[31];
            end
            OP_MUL_A2:
            begin
                mul_a    = 32'(om_reg);
                mul_b    = mag32(temp_reg);
                neg_next = temp_reg[31];
            end
            OP_MUL_V:
            begin
                mul_a    = mag32(s_reg);
                mul_b    = 32'(ex_reg);
                neg_next = s_reg[31];
            end
            OP_MUL_O:
            begin
                mul_a    = mag32(s3_reg);
                mul_b    = 32'(ex_reg);
                neg_next = s3_reg[31];
            end
            default:    mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_time_reg <= SMOOTH_TIME_RST;
            tick_time_reg   <= TICK_TIME_RST;
            max_speed_reg   <= MAX_SPEED_RST;
            vel_x_reg       <= '0;
            vel_y_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SMOOTH_TIME: smooth_time_reg <= cfg_wdata;
                    REG_TICK_TIME:   tick_time_reg   <= cfg_wdata;
                    REG_MAX_SPEED:   max_speed_reg   <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (cmd.op == OP_OUT)
            begin
                if (cmd.axis) vel_y_reg <= vel_next;
                else          vel_x_reg <= vel_next;
            end
            if (cmd.op == OP_EMIT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            neg_reg  <= neg_next;
        end
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                cur_x_reg <= s_tdata[31:0];
                cur_y_reg <= s_tdata[63:32];
                tgt_x_reg <= s_tdata[95:64];
                tgt_y_reg <= s_tdata[127:96];
            end
            OP_DIV_OM:   st_reg <= st_next;
            OP_WAIT_OM:
                if (div_done)
                    om_reg <= (|div_q[DIVD_W-1:CFG_W]) ? MAX_SPEED_RST : div_q[CFG_W-1:0];
            OP_TAKE_X:   x_reg <= prod_reg[PROD_W-1:FB];
            OP_TAKE_X2:  x2_reg <= (|x_reg[X_W-1:32]) ? UCAP : U_W'(prod_reg[PROD_W-1:FB]);
            OP_MUL_X3H, OP_MUL_T2H, OP_MUL_T3H:
                acc_reg <= ACC_W'(prod_reg);
            OP_ACC:      acc_reg <= acc_reg + {prod_reg[X_W-1:0], 32'd0};
            OP_TAKE_X3:
                x3_reg <= (x2_reg[U_W-1] || (|acc_reg[ACC_W-1:PROD_W]))
                          ? UCAP : U_W'(acc_reg[PROD_W-1:FB]);
            OP_TAKE_T2:
                d_reg <= ONE_D + D_W'(x_reg)
                         + (x2_reg[U_W-1] ? D_W'(UCAP) : D_W'(acc_reg[PROD_W-1:FB]));
            OP_TAKE_T3:
                d_reg <= d_reg
                         + (x3_reg[U_W-1] ? D_W'(UCAP) : D_W'(acc_reg[PROD_W-1:FB]));
            OP_WAIT_EX:
                if (div_done)
                    ex_reg <= div_q[EX_W-1:0];
            OP_TAKE_LIM:
                lim_reg <= (|prod_reg[PROD_W-1:FB+CFG_W])
                           ? MAX_SPEED_RST : prod_reg[FB+CFG_W-1:FB];
            OP_CHANGE:   change_reg <= change_next;
            OP_LIMTGT:   limtgt_reg <= sat32(sx34(cur_s) - sx34(change_reg));
            OP_S1:       s_reg <= sat32(sx34(vel_s) + sx34(qv));
            OP_TEMP:     temp_reg <= qv;
            OP_MUL_A2:   s3_reg <= sat32(sx34(change_reg) + sx34(temp_reg));
            OP_S2:       s_reg <= sat32(sx34(vel_s) - sx34(qv));
            OP_VEL:      vnew_reg <= qv;
            OP_OUT:
            begin
                if (cmd.axis)
                begin
                    res_py_reg <= out_next;
                    res_vy_reg <= vel_next;
                end
                else
                begin
                    res_px_reg <= out_next;
                    res_vx_reg <= vel_next;
                end
            end
            OP_EMIT:
                if (out_free)
                    m_tdata_reg <= {res_vy_reg, res_vx_reg, res_py_reg, res_px_reg};
            default:     ;
        endcase
    end

    assign sts.div_done = div_done;
    assign sts.out_free = out_free;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

    // an overshoot on x leaves the kept x velocity at zero
    a_snap_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT && !cmd.axis && ovs) |=> (vel_x_reg == 32'sd0))
        else $error("x velocity not cleared after overshoot");

endmodule

// ===== rtl/cds_ctrl.sv =====
module cds_ctrl
    import cds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     cfg_we,
    input  cds_sts_t sts,
    output cds_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONST,
        ST_AXIS,
        ST_EMIT
    } state_t;

    state_t          state_reg;
    logic [PC_W-1:0] pc_reg;
    logic            axis_reg;
    logic            cache_valid_reg;
    op_t             op;
    logic            hold;
    logic            const_last;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  op = s_tvalid ? OP_CAPTURE : OP_NOP;
            ST_CONST: op = CONST_PROG[pc_reg];
            ST_AXIS:  op = AXIS_PROG[pc_reg[APC_W-1:0]];
            ST_EMIT:  op = OP_EMIT;
            default:  op = OP_NOP;
        endcase
        hold = ((op == OP_WAIT_OM) || (op == OP_WAIT_EX)) && !sts.div_done;
        const_last = (state_reg == ST_CONST) && !hold && (pc_reg == PC_W'(CONST_LEN - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pc_reg          <= '0;
            axis_reg        <= 1'b0;
            cache_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (s_tvalid)
                    begin
                        pc_reg    <= '0;
                        axis_reg  <= 1'b0;
                        state_reg <= cache_valid_reg ? ST_AXIS : ST_CONST;
                    end
                ST_CONST:
                    if (!hold)
                    begin
                        if (pc_reg == PC_W'(CONST_LEN - 1))
                        begin
                            pc_reg    <= '0;
                            state_reg <= ST_AXIS;
                        end
                        else
                            pc_reg <= pc_reg + 1'b1;
                    end
                ST_AXIS:
                    if (pc_reg == PC_W'(AXIS_LEN - 1))
                    begin
                        pc_reg <= '0;
                        if (axis_reg) state_reg <= ST_EMIT;
                        else          axis_reg  <= 1'b1;
                    end
                    else
                        pc_reg <= pc_reg + 1'b1;
                ST_EMIT:
                    if (sts.out_free)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
            // constants depend on the registers, recompute after any write
            if (cfg_we)
                cache_valid_reg <= 1'b0;
            else if (const_last)
                cache_valid_reg <= 1'b1;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.op   = op;
    assign cmd.axis = axis_reg;

    a_axis_needs_const: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AXIS) |-> cache_valid_reg)
        else $error("axis step without constant terms");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !sts.out_free) |=> (state_reg == ST_EMIT))
        else $error("result dropped while output busy");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CONST || state_reg == ST_AXIS))
        else $error("accepted word not processed");

endmodule

// ===== rtl/critically_damped_smoothing_core.sv =====
// with the constant terms cached, an accepted word runs capture, both axis step lists and emit
// the first word after reset or after any register write first runs the 22 constant steps,
// which include the omega and exp divisions
// a new word is taken only once the last result is in the output register; all steps share one 32x32 multiplier
// reset: asynchronous active low, velocities cleared, registers to defaults
module critically_damped_smoothing_core
    import cds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // current_x, current_y, target_x, target_y
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // smoothed_x, smoothed_y, new_velocity_x, new_velocity_y
    // register write port
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,  // 0 smooth_time, 1 tick_time, 2 max_speed
    input  logic [CFG_W-1:0]  cfg_wdata
);

    // controller walks a fixed step list; datapath owns the multiplier,
    // divider, config registers, kept velocities and the output register
    cds_cmd_t cmd;
    cds_sts_t sts;

    cds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cfg_we   (cfg_we),
        .sts      (sts),
        .cmd      (cmd)
    );

    // the output register lets a new word be taken while a result waits
    cds_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== tb/smooth_damp_checker.sv =====
`timescale 1ns / 1ps

module smooth_damp_checker
    import cds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending,
    output int                words_checked
);

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } move_t;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam logic [63:0] CAP56 = 64'd1 << 56;

    move_t expected_moves[$];
    logic [63:0] smooth_q, tick_q, speed_q;
    longint vel_x_q, vel_y_q;

    function automatic longint clip32(input longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic logic [63:0] umul_cap(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        if (p[127:64] != 0) return CAP56;
        p = p >> FB;
        return (p[63:0] > CAP56) ? CAP56 : p[63:0];
    endfunction

    // truncate toward zero, then saturate
    function automatic longint fix_mul(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> FB;
        return clip32((p < 0) ? -m : m);
    endfunction

    function automatic longint axis_move(input longint cur, input longint tgt,
                                         inout longint vel, input longint om,
                                         input longint dt, input longint ex,
                                         input longint lim);
        longint change;
        longint lim_tgt;
        longint temp;
        longint res;
        change = clip32(cur - tgt);
        if (change > lim) change = lim;
        if (change < -lim) change = -lim;
        lim_tgt = clip32(cur - change);
        temp = fix_mul(clip32(vel + fix_mul(om, change)), dt);
        vel = fix_mul(clip32(vel - fix_mul(om, temp)), ex);
        res = clip32(lim_tgt + fix_mul(clip32(change + temp), ex));
        // overshoot snaps onto the goal and stops the axis
        if ((tgt > cur) == (res > tgt)) begin
            res = tgt;
            vel = 0;
        end
        return res;
    endfunction

    function automatic move_t damp_step(input logic [DATA_W-1:0] w);
        logic [63:0] st, om, x, x2, x3, d, ex, lim;
        move_t r;
        st = (smooth_q < 64'(FLOOR_V)) ? 64'(FLOOR_V) : smooth_q;
        om = (64'd1 << (2 * FB + 1)) / st;
        if (om > 64'(SMAX)) om = 64'(SMAX);
        x = umul_cap(om, tick_q);
        x2 = umul_cap(x, x);
        x3 = umul_cap(x2, x);
        d = 64'(ONE_I) + x + umul_cap(64'(K048_I), x2) + umul_cap(64'(K0235_I), x3);
        ex = (64'd1 << (2 * FB)) / d;
        lim = (speed_q * st) >> FB;
        if (lim > 64'(SMAX)) lim = 64'(SMAX);
        r.pos_x = 32'(axis_move(longint'($signed(w[31:0])), longint'($signed(w[95:64])),
                  vel_x_q, longint'(om), longint'(tick_q), longint'(ex), longint'(lim)));
        r.pos_y = 32'(axis_move(longint'($signed(w[63:32])), longint'($signed(w[127:96])),
                  vel_y_q, longint'(om), longint'(tick_q), longint'(ex), longint'(lim)));
        r.vel_x = 32'(vel_x_q);
        r.vel_y = 32'(vel_y_q);
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %0t %s: got %h want %h", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        move_t e;
        if (!rst_n)
        begin
            smooth_q = 64'(SMOOTH_TIME_RST);
            tick_q = 64'(TICK_TIME_RST);
            speed_q = 64'(MAX_SPEED_RST);
            vel_x_q = 0;
            vel_y_q = 0;
            expected_moves.delete();
            fail_count = 0;
            words_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SMOOTH_TIME: smooth_q = 64'(cfg_wdata);
                    REG_TICK_TIME:   tick_q = 64'(cfg_wdata);
                    REG_MAX_SPEED:   speed_q = 64'(cfg_wdata);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_moves.push_back(damp_step(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_moves.size() == 0)
                    report("unexpected word", m_tdata[31:0], 32'h0);
                else
                begin
                    e = expected_moves.pop_front();
                    words_checked++;
                    if (m_tdata[31:0] !== e.pos_x) report("smoothed_x", m_tdata[31:0], e.pos_x);
                    if (m_tdata[63:32] !== e.pos_y) report("smoothed_y", m_tdata[63:32], e.pos_y);
                    if (m_tdata[95:64] !== e.vel_x)
                        report("new_velocity_x", m_tdata[95:64], e.vel_x);
                    if (m_tdata[127:96] !== e.vel_y)
                        report("new_velocity_y", m_tdata[127:96], e.vel_y);
                end
            end
        end
        pending = expected_moves.size();
    end

endmodule

// ===== tb/critically_damped_smoothing_core_test.sv =====
`timescale 1ns / 1ps

module critically_damped_smoothing_core_test;
    import cds_pkg::*;

    // cycles with no handshake and no register write before the run is declared hung
    localparam int STALL_LIMIT = 20000;
    // index with no register behind it, writes must be dropped
    localparam logic [ADDR_W-1:0] REG_NONE = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // current_x, current_y, target_x, target_y
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // smoothed_x, smoothed_y, new_velocity_x, new_velocity_y
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    int fail_count;
    int pending;
    int words_checked;
    int words_sent;
    int phases_run;
    int quiet_cycles;
    int burst_left;
    int gap_max;
    int stall_mode;

    critically_damped_smoothing_core DUT (.*);

    smooth_damp_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure, pattern switches every so often
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready = 1'b1;
            1:       m_tready = ($urandom_range(0, 1) == 1);
            2:       m_tready = ($urandom_range(0, 7) == 0);
            default: m_tready = ($time / 4) % 5 != 0;
        endcase
    end

    task automatic cfg_write(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // registers only change with nothing in flight
    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (130) @(negedge clk);
    endtask

    // called at a falling edge; valid stays high between words of one burst
    task automatic send_word(input logic [DATA_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = w;
        do @(posedge clk); while (!s_tready);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] near(input logic [31:0] base);
        case ($urandom_range(0, 3))
            0:       return base + 32'($signed($urandom_range(0, 64)) - 32);
            1:       return base + 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            2:       return base + 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return base;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_move();
        logic [31:0] cx, cy;
        cx = $urandom;
        cy = $urandom;
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom, $urandom, $urandom};
            1:       return {cy, cx, cy, cx};
            2:       return {($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000), near(cx),
                             ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff), cx};
            default:
            begin
                // small working range keeps the velocity meaningful
                cx = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
                cy = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
                return {near(cy), near(cx), cy, cx};
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_word(random_move());
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_SMOOTH_TIME;
        cfg_wdata = '0;
        words_sent = 0;
        phases_run = 0;
        quiet_cycles = 0;
        burst_left = 0;
        gap_max = 6;
        stall_mode = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, goal above, below and equal
        send_word({32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff});
        send_word({32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
        send_word({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_word({32'h0001_0000, 32'hffff_0000, 32'h0000_0000, 32'h0000_0000});
        send_word({32'h0010_0000, 32'h0010_0000, 32'h0000_0000, 32'h0000_0000});
        send_word({32'h0010_0000, 32'h0010_0000, 32'h0008_0000, 32'h0008_0000});
        send_word({32'hfff0_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
        send_word({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_word({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_word({32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff});
        run_random(180);
        phases_run++;

        // smooth time under the floor, zero tick, zero speed, ignored index
        s_tvalid = 1'b0;
        wait_idle();
        cfg_write(REG_SMOOTH_TIME, '0);
        cfg_write(REG_TICK_TIME, '0);
        cfg_write(REG_MAX_SPEED, '0);
        cfg_write(REG_NONE, 31'h7fff_ffff);
        send_word({32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'hffff_0000});
        send_word({32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000});
        run_random(150);
        phases_run++;

        // zero tick with unlimited speed: pure exp of one
        s_tvalid = 1'b0;
        wait_idle();
        cfg_write(REG_MAX_SPEED, 31'h7fff_ffff);
        cfg_write(REG_SMOOTH_TIME, 31'd65536);
        run_random(120);
        phases_run++;

        // every register at its top value
        s_tvalid = 1'b0;
        wait_idle();
        cfg_write(REG_SMOOTH_TIME, 31'h7fff_ffff);
        cfg_write(REG_TICK_TIME, 31'h7fff_ffff);
        cfg_write(REG_MAX_SPEED, 31'h7fff_ffff);
        run_random(120);
        phases_run++;

        // smallest smooth time with a long tick drives the exp terms to their cap
        s_tvalid = 1'b0;
        wait_idle();
        cfg_write(REG_SMOOTH_TIME, 31'd1);
        cfg_write(REG_TICK_TIME, 31'd1 << 20);
        run_random(100);
        phases_run++;

        // random settings, some with no sender gaps at all
        repeat (7)
        begin
            s_tvalid = 1'b0;
            wait_idle();
            gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
            case ($urandom_range(0, 2))
                0:       cfg_write(REG_SMOOTH_TIME, 31'($urandom_range(0, 20)));
                1:       cfg_write(REG_SMOOTH_TIME, 31'($urandom_range(1000, 200000)));
                default: cfg_write(REG_SMOOTH_TIME, 31'($urandom));
            endcase
            case ($urandom_range(0, 2))
                0:       cfg_write(REG_TICK_TIME, 31'($urandom_range(0, 2000)));
                1:       cfg_write(REG_TICK_TIME, 31'($urandom_range(1, 1 << 17)));
                default: cfg_write(REG_TICK_TIME, 31'($urandom));
            endcase
            case ($urandom_range(0, 2))
                0:       cfg_write(REG_MAX_SPEED, 31'($urandom_range(0, 1 << 16)));
                1:       cfg_write(REG_MAX_SPEED, 31'($urandom_range(1 << 16, 1 << 24)));
                default: cfg_write(REG_MAX_SPEED, 31'($urandom));
            endcase
            run_random(110);
            phases_run++;
        end

        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);

        $display("sent %0d words over %0d register settings, %0d results checked",
                 words_sent, phases_run, words_checked);
        $display("covered floor, zero tick, zero and top speed, overshoot and extremes");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
